### rtl/core/rans_symbol_encoder_unit_macros.svh
// Assertion macros for the rANS symbol encoder unit.
// Included by rse_ctrl, which checks its own logic; no other dependencies.
`ifndef RANS_SYMBOL_ENCODER_UNIT_MACROS_SVH
`define RANS_SYMBOL_ENCODER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RSE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rse assertion failed");
`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rse assertion failed");
`else
`define RSE_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/rse_pkg.sv
// Shared types and constants for the rANS symbol encoder unit.
// No dependencies; used by rse_ctrl, rse_datapath and the top level.
package rse_pkg;

    localparam int STATE_W   = 32;
    localparam int SCALE     = 12;
    localparam int WORD_W    = 16;
    localparam int FREQ_W    = 13;
    localparam int START_W   = 12;
    localparam int QUO_W     = STATE_W - SCALE;
    localparam int CNT_W     = $clog2(QUO_W);
    localparam int IN_DATA_W = 32;

    localparam logic [STATE_W-1:0] STATE_INIT = STATE_W'(1) << WORD_W;
    localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(QUO_W - 1);

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT,
        ST_FLUSH_LO
    } t_state;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_RENORM,
        OUT_HI,
        OUT_LO
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     step;
        logic     commit;
        logic     flush_rst;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_flush;
        logic freq_zero;
        logic renorm;
        logic div_done;
    } t_dp_status;

endpackage

### rtl/core/rans_symbol_encoder_unit.sv
// Top level of the rANS symbol encoder (32-bit state, 12-bit scale, 16-bit words).
// Depends on rse_pkg, rse_ctrl and rse_datapath.
//
//  channel   dir  beat contents
//  s_axis    in   tdata[12:0] sym_freq, tdata[24:13] sym_start, tuser opcode
//  m_axis    out  tdata[15:0] out_word, tuser is_state, tlast last
//
// An encode item is accepted and renormalized, then runs through the radix-2
// divider (one quotient bit per cycle), then writes the new state. A flush sends
// the high then the low state half, waiting out any output stall; a zero-frequency item is dropped.
// The output register holds a beat while the divider runs; input waits only
// while an item is in progress or the output register is full and stalled.
// Synchronous active-low reset puts the coder state at 65536.
module rans_symbol_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rse_pkg::IN_DATA_W-1:0] s_axis_tdata,   // [12:0] sym_freq, [24:13] sym_start
    input  logic                          s_axis_tuser,   // [0] opcode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rse_pkg::WORD_W-1:0]    m_axis_tdata,   // [15:0] out_word
    output logic                          m_axis_tuser,   // [0] is_state
    output logic                          m_axis_tlast
);

    rse_pkg::t_dp_cmd    cmd;
    rse_pkg::t_dp_status status;

    rse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rse_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_data      (s_axis_tdata),
        .i_in_user      (s_axis_tuser),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_word     (m_axis_tdata),
        .o_out_is_state (m_axis_tuser),
        .o_out_last     (m_axis_tlast)
    );

endmodule

### rtl/core/rse_datapath.sv
// Datapath of the rANS encoder: coder state, radix-2 divider, output beat register.
// Depends on rse_pkg; driven by commands from rse_ctrl.
module rse_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [rse_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic                              i_in_user,
    input  rse_pkg::t_dp_cmd                  i_cmd,
    output rse_pkg::t_dp_status               o_status,
    output logic [rse_pkg::WORD_W-1:0]        o_out_word,
    output logic                              o_out_is_state,
    output logic                              o_out_last
);

    logic [rse_pkg::STATE_W-1:0] r_state, n_state;
    logic [rse_pkg::FREQ_W-1:0]  r_freq;
    logic [rse_pkg::START_W-1:0] r_start;
    logic [rse_pkg::FREQ_W-1:0]  r_rem, n_rem;
    logic [rse_pkg::QUO_W-1:0]   r_div, n_div;
    logic [rse_pkg::CNT_W-1:0]   r_cnt;
    logic [rse_pkg::WORD_W-1:0]  r_out_word;
    logic                        r_out_is_state;
    logic                        r_out_last;

    logic [rse_pkg::FREQ_W-1:0]  in_freq;
    logic [rse_pkg::START_W-1:0] in_start;
    logic                        renorm;
    logic [rse_pkg::STATE_W-1:0] x_sel;
    logic [rse_pkg::FREQ_W:0]    trial;
    logic [rse_pkg::FREQ_W:0]    trial_sub;
    logic                        q_bit;

    assign in_freq  = i_in_data[rse_pkg::FREQ_W-1:0];
    assign in_start = i_in_data[rse_pkg::FREQ_W +: rse_pkg::START_W];

    // Bound is freq << (32 - SCALE), compared at 33 bits so full scale never hits.
    assign renorm = {1'b0, r_state} >= {in_freq, {rse_pkg::QUO_W{1'b0}}};
    assign x_sel  = renorm ? (r_state >> rse_pkg::WORD_W) : r_state;

    assign trial     = {r_rem, r_div[rse_pkg::QUO_W-1]};
    assign q_bit     = trial >= {1'b0, r_freq};
    assign trial_sub = trial - {1'b0, r_freq};

    always_comb begin
        n_rem = r_rem;
        n_div = r_div;
        if (i_cmd.load) begin
            n_rem = rse_pkg::FREQ_W'(x_sel[rse_pkg::STATE_W-1:rse_pkg::QUO_W]);
            n_div = x_sel[rse_pkg::QUO_W-1:0];
        end else if (i_cmd.step) begin
            // shift one dividend bit in; quotient bits fill from the bottom
            n_rem = q_bit ? trial_sub[rse_pkg::FREQ_W-1:0] : trial[rse_pkg::FREQ_W-1:0];
            n_div = {r_div[rse_pkg::QUO_W-2:0], q_bit};
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_cmd.flush_rst) begin
            n_state = rse_pkg::STATE_INIT;
        end else if (i_cmd.commit) begin
            n_state = {r_div, {rse_pkg::SCALE{1'b0}}}
                    + rse_pkg::STATE_W'(r_rem)
                    + rse_pkg::STATE_W'(r_start);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::STATE_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.step) begin
                r_cnt <= r_cnt + rse_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_div <= n_div;
        if (i_cmd.load) begin
            r_freq  <= in_freq;
            r_start <= in_start;
        end
        case (i_cmd.out_sel)
            rse_pkg::OUT_RENORM: begin
                r_out_word     <= r_state[rse_pkg::WORD_W-1:0];
                r_out_is_state <= 1'b0;
                r_out_last     <= 1'b1;
            end
            rse_pkg::OUT_HI: begin
                r_out_word     <= r_state[rse_pkg::STATE_W-1:rse_pkg::WORD_W];
                r_out_is_state <= 1'b1;
                r_out_last     <= 1'b0;
            end
            rse_pkg::OUT_LO: begin
                r_out_word     <= r_state[rse_pkg::WORD_W-1:0];
                r_out_is_state <= 1'b1;
                r_out_last     <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_status.is_flush  = i_in_user == rse_pkg::OP_FLUSH;
    assign o_status.freq_zero = in_freq == '0;
    assign o_status.renorm    = renorm;
    assign o_status.div_done  = r_cnt == rse_pkg::CNT_LAST;

    assign o_out_word     = r_out_word;
    assign o_out_is_state = r_out_is_state;
    assign o_out_last     = r_out_last;

endmodule

### rtl/core/rse_ctrl.sv
// Controller of the rANS encoder: item sequencing and output beat valid.
// Depends on rse_pkg and rans_symbol_encoder_unit_macros.svh.
`include "rans_symbol_encoder_unit_macros.svh"

module rse_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  rse_pkg::t_dp_status i_status,
    output rse_pkg::t_dp_cmd    o_cmd
);

    rse_pkg::t_state r_st, n_st;
    logic            r_out_valid, n_out_valid;
    logic            slot_free;
    logic            accept;

    assign slot_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= rse_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_st       = r_st;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        accept     = 1'b0;
        case (r_st)
            rse_pkg::ST_IDLE: begin
                o_in_ready = slot_free;
                accept     = i_in_valid && slot_free;
                if (accept) begin
                    if (i_status.is_flush) begin
                        o_cmd.out_sel = rse_pkg::OUT_HI;
                        n_st          = rse_pkg::ST_FLUSH_LO;
                    end else if (!i_status.freq_zero) begin
                        o_cmd.load = 1'b1;
                        if (i_status.renorm) begin
                            o_cmd.out_sel = rse_pkg::OUT_RENORM;
                        end
                        n_st = rse_pkg::ST_DIV;
                    end
                end
            end
            rse_pkg::ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_done) begin
                    n_st = rse_pkg::ST_COMMIT;
                end
            end
            rse_pkg::ST_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_st         = rse_pkg::ST_IDLE;
            end
            rse_pkg::ST_FLUSH_LO: begin
                // wait for the high half to leave, then send low half and restart
                if (slot_free) begin
                    o_cmd.out_sel   = rse_pkg::OUT_LO;
                    o_cmd.flush_rst = 1'b1;
                    n_st            = rse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_st = rse_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_sel != rse_pkg::OUT_NONE) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `RSE_ASSERT_SAME(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_sel != rse_pkg::OUT_NONE, slot_free)
    `RSE_ASSERT_NEXT(a_flush_seq, i_clk, i_rst_n, accept && i_status.is_flush, r_st == rse_pkg::ST_FLUSH_LO && r_out_valid)
    `RSE_ASSERT_NEXT(a_div_end, i_clk, i_rst_n, r_st == rse_pkg::ST_DIV && i_status.div_done, r_st == rse_pkg::ST_COMMIT)
    `RSE_ASSERT_SAME(a_busy_stall, i_clk, i_rst_n, r_st != rse_pkg::ST_IDLE, !o_in_ready)

endmodule
